// ===== hdl/cbm_pkg.sv =====
// cbm_pkg: shared types and constants of the cartridge bank mapper
package cbm_pkg;

   localparam logic OPCODE_WRITE = 1'b0;
   localparam logic OPCODE_TICK  = 1'b1;

   localparam logic [1:0] CSR_PRG_SIZE    = 2'd0;
   localparam logic [1:0] CSR_CHR_SIZE    = 2'd1;
   localparam logic [1:0] CSR_FOUR_SCREEN = 2'd2;

   localparam logic [15:0] ADDR_DECODE_MASK    = 16'hE001;
   localparam logic [15:0] ADDR_BANK_SELECT    = 16'h8000;
   localparam logic [15:0] ADDR_BANK_DATA      = 16'h8001;
   localparam logic [15:0] ADDR_MIRRORING      = 16'hA000;
   localparam logic [15:0] ADDR_IRQ_COUNTER    = 16'hC000;
   localparam logic [15:0] ADDR_IRQ_RELOAD     = 16'hC001;
   localparam logic [15:0] ADDR_IRQ_DISABLE    = 16'hE000;
   localparam logic [15:0] ADDR_IRQ_ENABLE     = 16'hE001;

   localparam logic [2:0] TGT_CHR_PAIR_0 = 3'd0;
   localparam logic [2:0] TGT_CHR_PAIR_1 = 3'd1;
   localparam logic [2:0] TGT_CHR_4      = 3'd2;
   localparam logic [2:0] TGT_CHR_5      = 3'd3;
   localparam logic [2:0] TGT_CHR_6      = 3'd4;
   localparam logic [2:0] TGT_CHR_7      = 3'd5;
   localparam logic [2:0] TGT_PRG_A      = 3'd6;

   localparam logic [7:0] CHR_PAIR_MASK  = 8'hFE;
   localparam logic [7:0] CHR_PAIR_ODD   = 8'h01;
   localparam logic [2:0] CHR_SWAP_XOR   = 3'd4;
   localparam int         PRG_SWAP_BIT   = 6;
   localparam int         CHR_SWAP_BIT   = 7;

   localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

   localparam logic [3:0] OP_PRG_A     = 4'd0;
   localparam logic [3:0] OP_PRG_B     = 4'd1;
   localparam logic [3:0] OP_CHR_FIRST = 4'd2;
   localparam logic [3:0] OP_LAST      = 4'd9;

   localparam logic [3:0] MOD_STEPS = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_ITER,
      ST_NEXT,
      ST_OUT
   } cbm_state_type;

   typedef struct packed {
      logic accept;
      logic op_clear;
      logic mod_start;
      logic mod_step;
      logic store;
      logic op_next;
      logic out_load;
   } cbm_cmd_type;

   typedef struct packed {
      logic mod_done;
      logic op_last;
      logic out_free;
   } cbm_status_type;

endpackage

// ===== hdl/cbm_if.sv =====
// cbm_if: request and response channel interfaces
interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic [8:0]  scanline;
   logic        rendering_enabled;

   modport source (output valid, opcode, address, write_data, scanline, rendering_enabled,
                   input ready);
   modport sink (input valid, opcode, address, write_data, scanline, rendering_enabled,
                 output ready);
endinterface

interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  prg_page_0;
   logic [8:0]  prg_page_1;
   logic [8:0]  prg_page_2;
   logic [8:0]  prg_page_3;
   logic [63:0] chr_pages_packed;
   logic        chr_pages_valid;
   logic        irq_pulse;
   logic        mirroring_update;
   logic        mirroring_mode;

   modport source (output valid, prg_page_0, prg_page_1, prg_page_2, prg_page_3,
                   chr_pages_packed, chr_pages_valid, irq_pulse, mirroring_update,
                   mirroring_mode, input ready);
   modport sink (input valid, prg_page_0, prg_page_1, prg_page_2, prg_page_3,
                 chr_pages_packed, chr_pages_valid, irq_pulse, mirroring_update,
                 mirroring_mode, output ready);
endinterface

// ===== hdl/cartridge_bank_mapper_scanline_irq.sv =====
// cartridge_bank_mapper_scanline_irq: top level of the bank mapper with scanline irq
// Each request beat is a CPU register write or a scanline tick; it is applied to the
// mapper registers in the cycle it is accepted and yields one response beat with the
// four 8K program pages, eight 1K character pages and the irq and mirroring flags.
// The block holds one beat at a time: once it is accepted, the page numbers are
// reduced modulo the ROM sizes by a single bit-serial remainder unit in ten passes
// (two program banks, eight character windows), and then the output register is
// loaded. A new request is accepted while the previous response still waits to be
// taken.
// Configuration writes on the csr port take effect at once and must come while idle.
module cartridge_bank_mapper_scanline_irq
   import cbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cbm_req_if.sink    req_chan,
   cbm_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cbm_cmd_type    cmd;
   cbm_status_type status;

   cbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbm_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_opcode            (req_chan.opcode),
      .req_address           (req_chan.address),
      .req_write_data        (req_chan.write_data),
      .req_scanline          (req_chan.scanline),
      .req_rendering_enabled (req_chan.rendering_enabled),
      .rsp_ready             (rsp_chan.ready),
      .rsp_valid             (rsp_chan.valid),
      .rsp_prg_page_0        (rsp_chan.prg_page_0),
      .rsp_prg_page_1        (rsp_chan.prg_page_1),
      .rsp_prg_page_2        (rsp_chan.prg_page_2),
      .rsp_prg_page_3        (rsp_chan.prg_page_3),
      .rsp_chr_pages_packed  (rsp_chan.chr_pages_packed),
      .rsp_chr_pages_valid   (rsp_chan.chr_pages_valid),
      .rsp_irq_pulse         (rsp_chan.irq_pulse),
      .rsp_mirroring_update  (rsp_chan.mirroring_update),
      .rsp_mirroring_mode    (rsp_chan.mirroring_mode)
   );

endmodule

// ===== hdl/cbm_mod_unit.sv =====
// cbm_mod_unit: bit-serial restoring remainder of an 8-bit bank by a page count
module cbm_mod_unit
   import cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        step,
   input  logic [7:0]  dividend,
   input  logic [10:0] divisor,
   output logic [7:0]  remainder,
   output logic        done
);

   logic [7:0]  x_ff, x_in;
   logic [10:0] d_ff, d_in;
   logic [10:0] r_ff, r_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [11:0] shifted;
   logic [11:0] diff;

   always_comb begin
      shifted = {r_ff, x_ff[7]};
      diff    = shifted - {1'b0, d_ff};
      x_in    = x_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         x_in   = dividend;
         d_in   = divisor;
         r_in   = '0;
         cnt_in = '0;
      end else if (step) begin
         x_in   = {x_ff[6:0], 1'b0};
         r_in   = (shifted >= {1'b0, d_ff}) ? diff[10:0] : shifted[10:0];
         cnt_in = cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      d_ff <= d_in;
      r_ff <= r_in;
   end

   assign remainder = r_ff[7:0];
   assign done      = (cnt_ff == MOD_STEPS);

endmodule

// ===== hdl/cbm_datapath.sv =====
// cbm_datapath: mapper registers, irq counter, page remainders and output register
module cbm_datapath
   import cbm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cbm_cmd_type    cmd,
   output cbm_status_type status,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [7:0]     csr_wdata,
   input  logic           req_opcode,
   input  logic [15:0]    req_address,
   input  logic [7:0]     req_write_data,
   input  logic [8:0]     req_scanline,
   input  logic           req_rendering_enabled,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output logic [8:0]     rsp_prg_page_0,
   output logic [8:0]     rsp_prg_page_1,
   output logic [8:0]     rsp_prg_page_2,
   output logic [8:0]     rsp_prg_page_3,
   output logic [63:0]    rsp_chr_pages_packed,
   output logic           rsp_chr_pages_valid,
   output logic           rsp_irq_pulse,
   output logic           rsp_mirroring_update,
   output logic           rsp_mirroring_mode
);

   // configuration
   logic [7:0] prg_size_ff, chr_size_ff;
   logic       four_screen_ff;

   // mapper state
   logic [7:0] bank_select_ff, bank_select_in;
   logic [7:0] prg_bank_a_ff, prg_bank_a_in;
   logic [7:0] prg_bank_b_ff, prg_bank_b_in;
   logic [7:0] chr_bank_ff [8];
   logic [7:0] chr_bank_in [8];
   logic       irq_enable_ff, irq_enable_in;
   logic [7:0] irq_counter_ff, irq_counter_in;
   logic [7:0] irq_reload_ff, irq_reload_in;

   // per-beat flags and work results
   logic       pulse_ff, pulse_in;
   logic       mir_upd_ff, mir_upd_in;
   logic       mir_mode_ff, mir_mode_in;
   logic [3:0] op_ff, op_in;
   logic [7:0] a_res_ff, a_res_in;
   logic [7:0] b_res_ff, b_res_in;
   logic [7:0] chr_res_ff [8];
   logic [7:0] chr_res_in [8];

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [8:0]  out_prg0_ff, out_prg1_ff, out_prg2_ff, out_prg3_ff;
   logic [63:0] out_chr_ff;
   logic        out_chr_valid_ff, out_pulse_ff, out_mir_upd_ff, out_mir_mode_ff;

   logic [3:0]  op_chr_ofs;
   logic [2:0]  chr_idx;
   logic [2:0]  chr_src;
   logic [7:0]  mod_dividend;
   logic [10:0] mod_divisor;
   logic [7:0]  mod_rem;
   logic        mod_done;
   logic        tick_counts;
   logic [7:0]  prg_size_m1;
   logic [8:0]  page_a, page_b, page_m2, page_m1;
   logic [63:0] chr_packed;

   assign op_chr_ofs = op_ff - OP_CHR_FIRST;
   assign chr_idx    = op_chr_ofs[2:0];
   assign chr_src    = bank_select_ff[CHR_SWAP_BIT] ? (chr_idx ^ CHR_SWAP_XOR) : chr_idx;

   always_comb begin
      case (op_ff)
         OP_PRG_A: begin
            mod_dividend = prg_bank_a_ff;
            mod_divisor  = {2'b00, prg_size_ff, 1'b0};
         end
         OP_PRG_B: begin
            mod_dividend = prg_bank_b_ff;
            mod_divisor  = {2'b00, prg_size_ff, 1'b0};
         end
         default: begin
            mod_dividend = chr_bank_ff[chr_src];
            mod_divisor  = {chr_size_ff, 3'b000};
         end
      endcase
   end

   cbm_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .step      (cmd.mod_step),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .remainder (mod_rem),
      .done      (mod_done)
   );

   assign tick_counts = (req_scanline <= LAST_VISIBLE_LINE) && req_rendering_enabled
                        && irq_enable_ff;

   // item application
   always_comb begin
      bank_select_in = bank_select_ff;
      prg_bank_a_in  = prg_bank_a_ff;
      prg_bank_b_in  = prg_bank_b_ff;
      chr_bank_in    = chr_bank_ff;
      irq_enable_in  = irq_enable_ff;
      irq_counter_in = irq_counter_ff;
      irq_reload_in  = irq_reload_ff;
      pulse_in       = pulse_ff;
      mir_upd_in     = mir_upd_ff;
      mir_mode_in    = mir_mode_ff;
      if (cmd.accept) begin
         pulse_in    = 1'b0;
         mir_upd_in  = 1'b0;
         mir_mode_in = 1'b0;
         if (req_opcode == OPCODE_WRITE) begin
            case (req_address & ADDR_DECODE_MASK)
               ADDR_BANK_SELECT: bank_select_in = req_write_data;
               ADDR_BANK_DATA: begin
                  case (bank_select_ff[2:0])
                     TGT_CHR_PAIR_0: begin
                        chr_bank_in[0] = req_write_data & CHR_PAIR_MASK;
                        chr_bank_in[1] = (req_write_data & CHR_PAIR_MASK) | CHR_PAIR_ODD;
                     end
                     TGT_CHR_PAIR_1: begin
                        chr_bank_in[2] = req_write_data & CHR_PAIR_MASK;
                        chr_bank_in[3] = (req_write_data & CHR_PAIR_MASK) | CHR_PAIR_ODD;
                     end
                     TGT_CHR_4: chr_bank_in[4] = req_write_data;
                     TGT_CHR_5: chr_bank_in[5] = req_write_data;
                     TGT_CHR_6: chr_bank_in[6] = req_write_data;
                     TGT_CHR_7: chr_bank_in[7] = req_write_data;
                     TGT_PRG_A: prg_bank_a_in  = req_write_data;
                     default:   prg_bank_b_in  = req_write_data;
                  endcase
               end
               ADDR_MIRRORING: begin
                  if (!four_screen_ff) begin
                     mir_upd_in  = 1'b1;
                     mir_mode_in = ~req_write_data[0];
                  end
               end
               ADDR_IRQ_COUNTER: begin
                  irq_counter_in = req_write_data;
                  irq_enable_in  = 1'b1;
               end
               ADDR_IRQ_RELOAD:  irq_reload_in = req_write_data;
               ADDR_IRQ_DISABLE: irq_enable_in = 1'b0;
               ADDR_IRQ_ENABLE:  irq_enable_in = 1'b1;
               default: ;
            endcase
         end else if (tick_counts) begin
            if (irq_counter_ff == 8'd0) begin
               irq_counter_in = irq_reload_ff;
               pulse_in       = 1'b1;
            end else begin
               irq_counter_in = irq_counter_ff - 8'd1;
            end
         end
      end
   end

   // remainder sequencing
   always_comb begin
      op_in      = op_ff;
      a_res_in   = a_res_ff;
      b_res_in   = b_res_ff;
      chr_res_in = chr_res_ff;
      if (cmd.op_clear) begin
         op_in = OP_PRG_A;
      end else if (cmd.op_next) begin
         op_in = op_ff + 4'd1;
      end
      if (cmd.store) begin
         case (op_ff)
            OP_PRG_A: a_res_in = mod_rem;
            OP_PRG_B: b_res_in = mod_rem;
            default:  chr_res_in[chr_idx] = mod_rem;
         endcase
      end
   end

   assign prg_size_m1 = prg_size_ff - 8'd1;
   assign page_a      = {1'b0, a_res_ff};
   assign page_b      = {1'b0, b_res_ff};
   assign page_m2     = {prg_size_m1, 1'b0};
   assign page_m1     = {prg_size_m1, 1'b1};

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         chr_packed[8*k +: 8] = chr_res_ff[k];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_size_ff    <= 8'd2;
         chr_size_ff    <= 8'd1;
         four_screen_ff <= 1'b0;
         bank_select_ff <= '0;
         prg_bank_a_ff  <= '0;
         prg_bank_b_ff  <= 8'd1;
         for (int k = 0; k < 8; k++) begin
            chr_bank_ff[k] <= 8'(k);
         end
         irq_enable_ff  <= 1'b0;
         irq_counter_ff <= '0;
         irq_reload_ff  <= '0;
         op_ff          <= OP_PRG_A;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PRG_SIZE:    prg_size_ff    <= csr_wdata;
               CSR_CHR_SIZE:    chr_size_ff    <= csr_wdata;
               CSR_FOUR_SCREEN: four_screen_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         bank_select_ff <= bank_select_in;
         prg_bank_a_ff  <= prg_bank_a_in;
         prg_bank_b_ff  <= prg_bank_b_in;
         chr_bank_ff    <= chr_bank_in;
         irq_enable_ff  <= irq_enable_in;
         irq_counter_ff <= irq_counter_in;
         irq_reload_ff  <= irq_reload_in;
         op_ff          <= op_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pulse_ff    <= pulse_in;
      mir_upd_ff  <= mir_upd_in;
      mir_mode_ff <= mir_mode_in;
      a_res_ff    <= a_res_in;
      b_res_ff    <= b_res_in;
      chr_res_ff  <= chr_res_in;
      if (cmd.out_load) begin
         if (prg_size_ff == 8'd0) begin
            out_prg0_ff <= '0;
            out_prg1_ff <= '0;
            out_prg2_ff <= '0;
            out_prg3_ff <= '0;
         end else if (bank_select_ff[PRG_SWAP_BIT]) begin
            out_prg0_ff <= page_m2;
            out_prg1_ff <= page_b;
            out_prg2_ff <= page_a;
            out_prg3_ff <= page_m1;
         end else begin
            out_prg0_ff <= page_a;
            out_prg1_ff <= page_b;
            out_prg2_ff <= page_m2;
            out_prg3_ff <= page_m1;
         end
         out_chr_ff       <= (chr_size_ff == 8'd0) ? 64'd0 : chr_packed;
         out_chr_valid_ff <= (chr_size_ff != 8'd0);
         out_pulse_ff     <= pulse_ff;
         out_mir_upd_ff   <= mir_upd_ff;
         out_mir_mode_ff  <= mir_upd_ff & mir_mode_ff;
      end
   end

   assign status.mod_done = mod_done;
   assign status.op_last  = (op_ff == OP_LAST);
   assign status.out_free = ~out_valid_ff | rsp_ready;

   assign rsp_valid            = out_valid_ff;
   assign rsp_prg_page_0       = out_prg0_ff;
   assign rsp_prg_page_1       = out_prg1_ff;
   assign rsp_prg_page_2       = out_prg2_ff;
   assign rsp_prg_page_3       = out_prg3_ff;
   assign rsp_chr_pages_packed = out_chr_ff;
   assign rsp_chr_pages_valid  = out_chr_valid_ff;
   assign rsp_irq_pulse        = out_pulse_ff;
   assign rsp_mirroring_update = out_mir_upd_ff;
   assign rsp_mirroring_mode   = out_mir_mode_ff;

endmodule

// ===== hdl/cbm_ctrl.sv =====
// cbm_ctrl: controller state machine sequencing one beat through the datapath
module cbm_ctrl
   import cbm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  cbm_status_type status,
   output cbm_cmd_type    cmd
);

   cbm_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_START;
         ST_START: state_in = ST_ITER;
         ST_ITER:  if (status.mod_done) state_in = ST_NEXT;
         ST_NEXT:  state_in = status.op_last ? ST_OUT : ST_START;
         ST_OUT:   if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.accept   = req_valid;
            cmd.op_clear = req_valid;
         end
         ST_START: cmd.mod_start = 1'b1;
         ST_ITER:  cmd.mod_step  = ~status.mod_done;
         ST_NEXT: begin
            cmd.store   = 1'b1;
            cmd.op_next = ~status.op_last;
         end
         ST_OUT:  cmd.out_load = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/cbm_checker.sv =====
// cbm_checker: port-level assertions on the bank mapper, bound to the top level
module cbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [8:0]  rsp_prg_page_3,
   input logic [63:0] rsp_chr_pages_packed,
   input logic        rsp_chr_pages_valid,
   input logic        rsp_irq_pulse,
   input logic        rsp_mirroring_update,
   input logic        rsp_mirroring_mode
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_chr_pages_packed)
                                     && $stable(rsp_prg_page_3)))
      else $error("stalled response beat changed");

   a_tick_or_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_irq_pulse && rsp_mirroring_update))
      else $error("irq pulse and mirroring update in one beat");

   a_mode_needs_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mirroring_mode) |-> rsp_mirroring_update)
      else $error("mirroring mode without update");

   a_chr_ram_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_chr_pages_valid) |-> (rsp_chr_pages_packed == 64'd0))
      else $error("character pages reported for character ram");

endmodule

bind cartridge_bank_mapper_scanline_irq cbm_checker u_cbm_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_prg_page_3       (rsp_chan.prg_page_3),
   .rsp_chr_pages_packed (rsp_chan.chr_pages_packed),
   .rsp_chr_pages_valid  (rsp_chan.chr_pages_valid),
   .rsp_irq_pulse        (rsp_chan.irq_pulse),
   .rsp_mirroring_update (rsp_chan.mirroring_update),
   .rsp_mirroring_mode   (rsp_chan.mirroring_mode)
);

// ===== tb/tb.sv =====
// tb: self-checking testbench for the cartridge bank mapper with scanline irq
import cbm_pkg::*;

typedef struct packed {
   logic        opcode;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic [8:0]  scanline;
   logic        rendering_enabled;
} req_beat_type;

typedef struct packed {
   logic [8:0]  prg_page_0;
   logic [8:0]  prg_page_1;
   logic [8:0]  prg_page_2;
   logic [8:0]  prg_page_3;
   logic [63:0] chr_pages_packed;
   logic        chr_pages_valid;
   logic        irq_pulse;
   logic        mirroring_update;
   logic        mirroring_mode;
} page_map_type;

class mapper_scoreboard;
   logic [7:0] prg_size;
   logic [7:0] chr_size;
   logic       four_screen;
   logic [7:0] bank_select;
   logic [7:0] prg_bank_a;
   logic [7:0] prg_bank_b;
   logic [7:0] chr_bank [8];
   logic       irq_enable;
   logic [7:0] irq_counter;
   logic [7:0] irq_reload;
   page_map_type expected_maps [$];
   int         errors;

   function new();
      prg_size    = 8'd2;
      chr_size    = 8'd1;
      four_screen = 1'b0;
      bank_select = 8'd0;
      prg_bank_a  = 8'd0;
      prg_bank_b  = 8'd1;
      for (int k = 0; k < 8; k++) chr_bank[k] = 8'(k);
      irq_enable  = 1'b0;
      irq_counter = 8'd0;
      irq_reload  = 8'd0;
      errors      = 0;
   endfunction

   function void set_config(logic [1:0] index, logic [7:0] value);
      case (index)
         CSR_PRG_SIZE:    prg_size = value;
         CSR_CHR_SIZE:    chr_size = value;
         CSR_FOUR_SCREEN: four_screen = value[0];
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_maps.size();
   endfunction

   // update the mapper state with one accepted beat and queue the page map it yields
   function void apply_beat(req_beat_type r);
      page_map_type m;
      logic [7:0] d;
      int         p;
      int         cnt;
      int         src;
      m = '0;
      d = r.write_data;
      if (r.opcode == OPCODE_WRITE) begin
         case (r.address & ADDR_DECODE_MASK)
            ADDR_BANK_SELECT: bank_select = d;
            ADDR_BANK_DATA: begin
               case (bank_select[2:0])
                  TGT_CHR_PAIR_0: begin
                     chr_bank[0] = d & CHR_PAIR_MASK;
                     chr_bank[1] = (d & CHR_PAIR_MASK) | CHR_PAIR_ODD;
                  end
                  TGT_CHR_PAIR_1: begin
                     chr_bank[2] = d & CHR_PAIR_MASK;
                     chr_bank[3] = (d & CHR_PAIR_MASK) | CHR_PAIR_ODD;
                  end
                  TGT_CHR_4: chr_bank[4] = d;
                  TGT_CHR_5: chr_bank[5] = d;
                  TGT_CHR_6: chr_bank[6] = d;
                  TGT_CHR_7: chr_bank[7] = d;
                  TGT_PRG_A: prg_bank_a = d;
                  default:   prg_bank_b = d;
               endcase
            end
            ADDR_MIRRORING: begin
               if (!four_screen) begin
                  m.mirroring_update = 1'b1;
                  m.mirroring_mode   = ~d[0];
               end
            end
            ADDR_IRQ_COUNTER: begin
               irq_counter = d;
               irq_enable  = 1'b1;
            end
            ADDR_IRQ_RELOAD:  irq_reload = d;
            ADDR_IRQ_DISABLE: irq_enable = 1'b0;
            ADDR_IRQ_ENABLE:  irq_enable = 1'b1;
            default: ;
         endcase
      end else if (r.scanline <= LAST_VISIBLE_LINE && r.rendering_enabled && irq_enable) begin
         if (irq_counter == 8'd0) begin
            irq_counter = irq_reload;
            m.irq_pulse = 1'b1;
         end else begin
            irq_counter = irq_counter - 8'd1;
         end
      end
      p = 2 * int'(prg_size);
      if (p != 0) begin
         if (bank_select[PRG_SWAP_BIT]) begin
            m.prg_page_0 = 9'(p - 2);
            m.prg_page_1 = 9'(int'(prg_bank_b) % p);
            m.prg_page_2 = 9'(int'(prg_bank_a) % p);
         end else begin
            m.prg_page_0 = 9'(int'(prg_bank_a) % p);
            m.prg_page_1 = 9'(int'(prg_bank_b) % p);
            m.prg_page_2 = 9'(p - 2);
         end
         m.prg_page_3 = 9'(p - 1);
      end
      cnt = 8 * int'(chr_size);
      m.chr_pages_valid = (cnt != 0);
      if (cnt != 0) begin
         for (int k = 0; k < 8; k++) begin
            src = bank_select[CHR_SWAP_BIT] ? (k ^ int'(CHR_SWAP_XOR)) : k;
            m.chr_pages_packed[8*k +: 8] = 8'(int'(chr_bank[src]) % cnt);
         end
      end
      expected_maps.push_back(m);
   endfunction

   task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_page_map(page_map_type got);
      page_map_type want;
      if (expected_maps.size() == 0) begin
         report("response beat with no request outstanding");
         return;
      end
      want = expected_maps.pop_front();
      if (got.prg_page_0 !== want.prg_page_0)
         report($sformatf("prg_page_0 exp %0d got %0d", want.prg_page_0, got.prg_page_0));
      if (got.prg_page_1 !== want.prg_page_1)
         report($sformatf("prg_page_1 exp %0d got %0d", want.prg_page_1, got.prg_page_1));
      if (got.prg_page_2 !== want.prg_page_2)
         report($sformatf("prg_page_2 exp %0d got %0d", want.prg_page_2, got.prg_page_2));
      if (got.prg_page_3 !== want.prg_page_3)
         report($sformatf("prg_page_3 exp %0d got %0d", want.prg_page_3, got.prg_page_3));
      if (got.chr_pages_packed !== want.chr_pages_packed)
         report($sformatf("chr_pages_packed exp %h got %h",
                          want.chr_pages_packed, got.chr_pages_packed));
      if (got.chr_pages_valid !== want.chr_pages_valid)
         report($sformatf("chr_pages_valid exp %b got %b",
                          want.chr_pages_valid, got.chr_pages_valid));
      if (got.irq_pulse !== want.irq_pulse)
         report($sformatf("irq_pulse exp %b got %b", want.irq_pulse, got.irq_pulse));
      if (got.mirroring_update !== want.mirroring_update)
         report($sformatf("mirroring_update exp %b got %b",
                          want.mirroring_update, got.mirroring_update));
      if (got.mirroring_mode !== want.mirroring_mode)
         report($sformatf("mirroring_mode exp %b got %b",
                          want.mirroring_mode, got.mirroring_mode));
   endtask
endclass

module tb;
   localparam int CYCLE_LIMIT = 600000;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;
   bit         rsp_hold_off;
   bit         no_idle;
   int         line_no;
   int         cycle_count;

   mapper_scoreboard sb;

   cbm_req_if req_bus ();
   cbm_rsp_if rsp_bus ();

   cartridge_bank_mapper_scanline_irq u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // beat monitor: response first, so a same-edge request queues behind it
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_page_map({rsp_bus.prg_page_0, rsp_bus.prg_page_1, rsp_bus.prg_page_2,
                               rsp_bus.prg_page_3, rsp_bus.chr_pages_packed,
                               rsp_bus.chr_pages_valid, rsp_bus.irq_pulse,
                               rsp_bus.mirroring_update, rsp_bus.mirroring_mode});
         if (req_bus.valid && req_bus.ready)
            sb.apply_beat({req_bus.opcode, req_bus.address, req_bus.write_data,
                           req_bus.scanline, req_bus.rendering_enabled});
      end
   end

   // response side back-pressure
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      forever begin
         if (rsp_hold_off) begin
            rsp_hold_off = 1'b0;
            repeat (400) begin
               @(posedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end else if (!no_idle && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
               @(posedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end else begin
            n = no_idle ? 1 : $urandom_range(1, 30);
            repeat (n) begin
               @(posedge clock);
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[cartridge_bank_mapper_scanline_irq] ERROR");
      $finish;
   end

   task drive_beat(logic op, logic [15:0] addr, logic [7:0] data, logic [8:0] line,
                   logic rend);
      if (!no_idle && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.opcode            <= op;
      req_bus.address           <= addr;
      req_bus.write_data        <= data;
      req_bus.scanline          <= line;
      req_bus.rendering_enabled <= rend;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // unused tick fields are randomised on a write and vice versa
   task send_write(logic [15:0] addr, logic [7:0] data);
      drive_beat(OPCODE_WRITE, addr, data, 9'($urandom), 1'($urandom));
   endtask

   task send_tick(logic [8:0] line, logic rend);
      drive_beat(OPCODE_TICK, 16'($urandom), 8'($urandom), line, rend);
   endtask

   function logic [15:0] decoded_addr(logic [15:0] base);
      return (base & ADDR_DECODE_MASK) | (16'($urandom) & ~ADDR_DECODE_MASK);
   endfunction

   // the monitor has noted the last accepted beat once this edge has passed
   task wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task program_csr(logic [7:0] prg, logic [7:0] chr, logic four);
      csr_we    <= 1'b1;
      csr_index <= CSR_PRG_SIZE;
      csr_wdata <= prg;
      sb.set_config(CSR_PRG_SIZE, prg);
      @(posedge clock);
      csr_index <= CSR_CHR_SIZE;
      csr_wdata <= chr;
      sb.set_config(CSR_CHR_SIZE, chr);
      @(posedge clock);
      csr_index <= CSR_FOUR_SCREEN;
      csr_wdata <= {7'd0, four};
      sb.set_config(CSR_FOUR_SCREEN, {7'd0, four});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task random_traffic(int target);
      int         sent;
      logic [15:0] misc_addr;
      sent = 0;
      while (sent < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               if ($urandom_range(0, 9) == 0) line_no = $urandom_range(0, 511);
               else line_no = (line_no >= 261) ? 0 : line_no + 1;
               send_tick(9'(line_no), $urandom_range(0, 7) != 0);
               sent++;
            end
            4, 5: begin
               send_write(decoded_addr(ADDR_BANK_SELECT), 8'($urandom));
               send_write(decoded_addr(ADDR_BANK_DATA), 8'($urandom));
               sent += 2;
            end
            6: begin
               send_write(decoded_addr(ADDR_IRQ_RELOAD),
                          ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
               send_write(decoded_addr(ADDR_IRQ_COUNTER), 8'($urandom_range(0, 7)));
               sent += 2;
            end
            7: begin
               case ($urandom_range(0, 3))
                  0:       misc_addr = ADDR_MIRRORING;
                  1:       misc_addr = ADDR_IRQ_DISABLE;
                  default: misc_addr = ADDR_IRQ_ENABLE;
               endcase
               send_write(decoded_addr(misc_addr), 8'($urandom));
               sent++;
            end
            8: begin
               send_write(decoded_addr(ADDR_BANK_DATA), 8'($urandom));
               sent++;
            end
            default: begin
               send_write(16'($urandom), 8'($urandom));
               sent++;
            end
         endcase
      end
   endtask

   initial begin
      logic [2:0] t;
      logic [7:0] prg;
      logic [7:0] chr;
      sb           = new();
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = CSR_PRG_SIZE;
      csr_wdata    = 8'd0;
      rsp_hold_off = 1'b0;
      no_idle      = 1'b0;
      line_no      = 0;
      req_bus.valid             = 1'b0;
      req_bus.opcode            = OPCODE_WRITE;
      req_bus.address           = 16'd0;
      req_bus.write_data        = 8'd0;
      req_bus.scanline          = 9'd0;
      req_bus.rendering_enabled = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: undecoded write, every bank target, both states of each swap bit, mirroring
      send_tick(9'd0, 1'b0);
      send_write(16'h7FFF, 8'hFF);
      for (int i = 0; i < 8; i++) begin
         t = 3'(i);
         send_write(ADDR_BANK_SELECT, {t[1], t[0], 3'b000, t});
         send_write(ADDR_BANK_DATA, t[0] ? 8'h00 : 8'hFF);
      end
      send_write(ADDR_MIRRORING, 8'h00);
      send_write(16'hBFFE, 8'h01);
      send_write(16'hA001, 8'hFF);
      // irq counter: reload, pulse, invisible lines, disable and enable
      send_write(ADDR_IRQ_RELOAD, 8'd1);
      send_write(ADDR_IRQ_COUNTER, 8'd0);
      send_tick(LAST_VISIBLE_LINE, 1'b1);
      send_tick(9'd240, 1'b1);
      send_write(ADDR_IRQ_DISABLE, 8'h00);
      send_tick(9'd0, 1'b1);
      send_write(16'hFFFF, 8'hFF);
      send_tick(9'd511, 1'b1);
      send_tick(9'd0, 1'b1);
      send_tick(9'd1, 1'b1);

      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         case (phase)
            0: program_csr(8'd255, 8'd0, 1'b1);
            1: program_csr(8'd1, 8'd255, 1'b0);
            default: begin
               prg = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 4))
                                                 : 8'($urandom_range(1, 255));
               chr = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, 255));
               program_csr(prg, chr, 1'($urandom));
            end
         endcase
         if (phase == 3) rsp_hold_off = 1'b1;
         if (phase == 7) no_idle = 1'b1;
         random_traffic(100);
      end

      wait_drained();
      repeat (150) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[cartridge_bank_mapper_scanline_irq] OK");
      end else begin
         $display("[cartridge_bank_mapper_scanline_irq] ERROR");
      end
      $finish;
   end
endmodule
